/* sv/assert_macros.svh */
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define TCG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define TCG_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

`else

`define TCG_ASSERT(lbl, prop)

`define TCG_ASSERT_MSG(lbl, prop, msg)

`endif

`endif

/* sv/tcg_pkg.sv */
package tcg_pkg;

  localparam int GLYPH_COUNT = 96;
  localparam int GLYPH_SIZE  = 16;
  localparam int FONT_DEPTH  = 3072;
  localparam int BANK_DEPTH  = FONT_DEPTH / 2;
  localparam int BANK_AW     = $clog2(BANK_DEPTH);
  localparam int ROW_W       = $clog2(GLYPH_SIZE);
  localparam int CNT_W       = ROW_W + 1;
  localparam int GLYPH_W     = BANK_AW - ROW_W;

  localparam logic [1:0] ACT_CHAR   = 2'd0;
  localparam logic [1:0] ACT_CURSOR = 2'd1;
  localparam logic [1:0] ACT_FONT   = 2'd2;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_FIRST = 8'd32;

  localparam logic [2:0] CFG_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_PITCH  = 3'd2;
  localparam logic [2:0] CFG_BPP    = 3'd3;
  localparam logic [2:0] CFG_INK    = 3'd4;
  localparam logic [2:0] CFG_PAPER  = 3'd5;

  localparam logic [12:0] WIDTH_RST  = 13'd1024;
  localparam logic [12:0] HEIGHT_RST = 13'd768;
  localparam logic [15:0] PITCH_RST  = 16'd4096;
  localparam logic [2:0]  BPP_RST    = 3'd4;
  localparam logic [23:0] INK_RST    = 24'h000000;
  localparam logic [23:0] PAPER_RST  = 24'hffffff;

  localparam logic [13:0] COORD_MAX = 14'h1fff;
  localparam logic [13:0] TAB_STEP  = 14'(4 * GLYPH_SIZE);

  typedef logic [12:0] coord_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_FILL,
    KIND_GLYPH
  } kind_t;

  typedef struct packed {
    logic             accept;
    logic             prep_a;
    logic             prep_b;
    logic             issue;
    logic             last;
    logic [ROW_W-1:0] row;
  } tcg_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] n_rows;
    logic             adv;
  } tcg_status_t;

endpackage

/* sv/text_console_glyph_renderer.sv */
// channel | handshake          | payload
// in      | in_valid/in_stall   | action, char_code, new_x, new_y, font_addr, font_byte
// out     | out_valid/out_stall | row_valid, pixel_x/y, byte_offset, pixel_mask, row_color,
//         |                     | cursor_x/y, last
// cfg     | cfg_we              | cfg_index, cfg_data
//
// an item sends max(rows, 1) transfers: 16 for a full glyph row set
// rows leave at one per cycle while out_stall is low, paced by the two-bank font read and the row counter
// accept in ST_IDLE, setup in ST_PREP_A (offset multiply) and ST_PREP_B (offset add), rows, then ST_DRAIN
// rst_n is synchronous; it resets cursor, config registers and control, the font memory is kept
// out_stall freezes the row pipeline; input stays stalled until the last row is in the out stage
module text_console_glyph_renderer
  import tcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_char_code,
  input  logic [12:0] in_new_x,
  input  logic [12:0] in_new_y,
  input  logic [11:0] in_font_addr,
  input  logic [7:0]  in_font_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_row_valid,
  output logic [12:0] out_pixel_x,
  output logic [12:0] out_pixel_y,
  output logic [27:0] out_byte_offset,
  output logic [15:0] out_pixel_mask,
  output logic [23:0] out_row_color,
  output logic [12:0] out_cursor_x,
  output logic [12:0] out_cursor_y,
  output logic        out_last
);

  tcg_cmd_t    cmd;
  tcg_status_t status;

  tcg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tcg_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_action       (in_action),
    .in_char_code    (in_char_code),
    .in_new_x        (in_new_x),
    .in_new_y        (in_new_y),
    .in_font_addr    (in_font_addr),
    .in_font_byte    (in_font_byte),
    .cmd             (cmd),
    .status          (status),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_row_valid   (out_row_valid),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_byte_offset (out_byte_offset),
    .out_pixel_mask  (out_pixel_mask),
    .out_row_color   (out_row_color),
    .out_cursor_x    (out_cursor_x),
    .out_cursor_y    (out_cursor_y),
    .out_last        (out_last)
  );

endmodule

/* sv/tcg_datapath.sv */
module tcg_datapath
  import tcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_char_code,
  input  logic [12:0] in_new_x,
  input  logic [12:0] in_new_y,
  input  logic [11:0] in_font_addr,
  input  logic [7:0]  in_font_byte,
  input  tcg_cmd_t    cmd,
  output tcg_status_t status,
  input  logic        out_stall,
  output logic        out_valid,
  output logic        out_row_valid,
  output logic [12:0] out_pixel_x,
  output logic [12:0] out_pixel_y,
  output logic [27:0] out_byte_offset,
  output logic [15:0] out_pixel_mask,
  output logic [23:0] out_row_color,
  output logic [12:0] out_cursor_x,
  output logic [12:0] out_cursor_y,
  output logic        out_last
);

  coord_t      width_r, height_r;
  logic [15:0] pitch_r;
  logic [2:0]  bpp_r;
  logic [23:0] ink_r, paper_r;
  coord_t      col_r, line_r;

  coord_t             draw_x_r;
  kind_t              kind_r;
  logic [GLYPH_W-1:0] glyph_r;
  logic [27:0]        prod_r;
  logic [15:0]        xb_r;
  logic [CNT_W-1:0]   n_rows_r;
  logic [15:0]        clip_r;
  logic [13:0]        y_cnt_r;
  logic [27:0]        off_cnt_r;

  logic        b_valid_r, b_row_r, b_last_r;
  logic [13:0] b_y_r;
  logic [27:0] b_off_r;

  logic [7:0] bank0 [BANK_DEPTH];
  logic [7:0] bank1 [BANK_DEPTH];
  logic [7:0] rd0_r, rd1_r;

  logic        out_valid_r, out_row_r, out_last_r;
  coord_t      out_x_r, out_y_r, out_cx_r, out_cy_r;
  logic [27:0] out_off_r;
  logic [15:0] out_mask_r;
  logic [23:0] out_color_r;

  logic        adv;
  logic        wrap, is_glyph, font_we;
  coord_t      x0, l0, bs_x, col_nxt, line_nxt, draw_nxt;
  kind_t       kind_nxt;
  logic [13:0] sum_tab, sum_g;
  logic [28:0] prod_full;
  logic [12:0] diff;
  logic [CNT_W-1:0] n_nxt;
  logic [15:0] clip_nxt;
  logic [BANK_AW-1:0] raddr;

  assign adv = !out_valid_r || !out_stall;
  assign status.adv = adv;
  assign status.n_rows = n_rows_r;

  // cursor update of one item, including the wrap at the line end
  always_comb begin
    wrap = (in_action == ACT_CHAR) && (in_char_code != CH_NL) && (col_r >= width_r);
    x0 = wrap ? '0 : col_r;
    l0 = ((in_action == ACT_CHAR) && ((in_char_code == CH_NL) || wrap)) ?
         13'(line_r + 13'(GLYPH_SIZE)) : line_r;
    is_glyph = (in_char_code >= CH_FIRST) && (8'(in_char_code - CH_FIRST) < 8'(GLYPH_COUNT));
    sum_tab = {1'b0, x0} + TAB_STEP;
    sum_g = {1'b0, x0} + 14'(GLYPH_SIZE);
    bs_x = (x0 >= 13'(GLYPH_SIZE)) ? 13'(x0 - 13'(GLYPH_SIZE)) : '0;
    col_nxt = col_r;
    line_nxt = line_r;
    draw_nxt = x0;
    kind_nxt = KIND_NONE;
    case (in_action)
      ACT_CURSOR: begin
        col_nxt = in_new_x;
        line_nxt = in_new_y;
      end
      ACT_CHAR: begin
        line_nxt = l0;
        if (in_char_code == CH_NL) begin
          col_nxt = '0;
        end else if (in_char_code == CH_TAB) begin
          col_nxt = (sum_tab > COORD_MAX) ? COORD_MAX[12:0] : sum_tab[12:0];
        end else if (in_char_code == CH_BS) begin
          col_nxt = bs_x;
          draw_nxt = bs_x;
          kind_nxt = KIND_FILL;
        end else if (is_glyph) begin
          col_nxt = (sum_g > COORD_MAX) ? COORD_MAX[12:0] : sum_g[12:0];
          kind_nxt = KIND_GLYPH;
        end else begin
          col_nxt = x0;
        end
      end
      default: begin
        col_nxt = col_r;
      end
    endcase
  end

  assign font_we = cmd.accept && (in_action == ACT_FONT) && (in_font_addr < 12'(FONT_DEPTH));

  // row count, clip mask and offset terms
  always_comb begin
    prod_full = line_r * pitch_r;
    diff = 13'(height_r - line_r);
    if ((kind_r == KIND_NONE) || (height_r <= line_r)) begin
      n_nxt = '0;
    end else if (diff >= 13'(GLYPH_SIZE)) begin
      n_nxt = CNT_W'(GLYPH_SIZE);
    end else begin
      n_nxt = diff[CNT_W-1:0];
    end
    for (int p = 0; p < 16; p++) begin
      clip_nxt[15-p] = (p < GLYPH_SIZE) &&
                       (({1'b0, draw_x_r} + 14'(p)) < {1'b0, width_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      pitch_r <= PITCH_RST;
      bpp_r <= BPP_RST;
      ink_r <= INK_RST;
      paper_r <= PAPER_RST;
      col_r <= '0;
      line_r <= '0;
      kind_r <= KIND_NONE;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WIDTH:  width_r <= cfg_data[12:0];
          CFG_HEIGHT: height_r <= cfg_data[12:0];
          CFG_PITCH:  pitch_r <= cfg_data[15:0];
          CFG_BPP:    bpp_r <= cfg_data[2:0];
          CFG_INK:    ink_r <= cfg_data;
          CFG_PAPER:  paper_r <= cfg_data;
          default:    width_r <= width_r;
        endcase
      end
      if (cmd.accept) begin
        col_r <= col_nxt;
        line_r <= line_nxt;
        kind_r <= kind_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      draw_x_r <= draw_nxt;
      glyph_r <= GLYPH_W'(in_char_code - CH_FIRST);
    end
    if (cmd.prep_a) begin
      prod_r <= prod_full[27:0];
      xb_r <= 16'(draw_x_r) * 16'(bpp_r);
      n_rows_r <= n_nxt;
      clip_r <= clip_nxt;
    end
    if (cmd.prep_b) begin
      off_cnt_r <= prod_r + 28'(xb_r);
      y_cnt_r <= {1'b0, line_r};
    end else if (cmd.issue) begin
      off_cnt_r <= off_cnt_r + 28'(pitch_r);
      y_cnt_r <= y_cnt_r + 14'd1;
    end
    if (cmd.issue) begin
      b_row_r <= (n_rows_r != '0);
      b_y_r <= y_cnt_r;
      b_off_r <= off_cnt_r;
      b_last_r <= cmd.last;
    end
  end

  assign raddr = {glyph_r, cmd.row};

  // left byte of each glyph row
  always_ff @(posedge clk) begin
    if (font_we && !in_font_addr[0]) begin
      bank0[in_font_addr[BANK_AW:1]] <= in_font_byte;
    end
    if (cmd.issue) begin
      rd0_r <= bank0[raddr];
    end
  end

  // right byte of each glyph row
  always_ff @(posedge clk) begin
    if (font_we && in_font_addr[0]) begin
      bank1[in_font_addr[BANK_AW:1]] <= in_font_byte;
    end
    if (cmd.issue) begin
      rd1_r <= bank1[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.issue) begin
        b_valid_r <= 1'b1;
      end else if (adv) begin
        b_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b_valid_r) begin
      out_row_r <= b_row_r;
      out_last_r <= b_last_r;
      out_cx_r <= col_r;
      out_cy_r <= line_r;
      if (b_row_r) begin
        out_x_r <= draw_x_r;
        out_y_r <= b_y_r[12:0];
        out_off_r <= b_off_r;
        out_mask_r <= ((kind_r == KIND_GLYPH) ? {rd0_r, rd1_r} : 16'hffff) & clip_r;
        out_color_r <= (kind_r == KIND_FILL) ? paper_r : ink_r;
      end else begin
        out_x_r <= '0;
        out_y_r <= '0;
        out_off_r <= '0;
        out_mask_r <= '0;
        out_color_r <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_row_valid = out_row_r;
  assign out_pixel_x = out_x_r;
  assign out_pixel_y = out_y_r;
  assign out_byte_offset = out_off_r;
  assign out_pixel_mask = out_mask_r;
  assign out_row_color = out_color_r;
  assign out_cursor_x = out_cx_r;
  assign out_cursor_y = out_cy_r;
  assign out_last = out_last_r;

endmodule

/* sv/tcg_ctrl.sv */
`include "assert_macros.svh"

module tcg_ctrl
  import tcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  tcg_status_t status,
  output tcg_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP_A,
    ST_PREP_B,
    ST_ROWS,
    ST_DRAIN
  } state_t;

  state_t           state_r;
  logic [ROW_W-1:0] cnt_r;
  logic [ROW_W-1:0] total_m1;

  // a suppressed item still sends one transfer
  assign total_m1 = (status.n_rows == '0) ? '0 : ROW_W'(status.n_rows - CNT_W'(1));

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd.accept = (state_r == ST_IDLE) && in_valid;
    cmd.prep_a = (state_r == ST_PREP_A);
    cmd.prep_b = (state_r == ST_PREP_B);
    cmd.issue = (state_r == ST_ROWS) && status.adv;
    cmd.last = (cnt_r == total_m1);
    cmd.row = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_PREP_A;
          end
        end
        ST_PREP_A: begin
          state_r <= ST_PREP_B;
        end
        ST_PREP_B: begin
          cnt_r <= '0;
          state_r <= ST_ROWS;
        end
        ST_ROWS: begin
          if (status.adv) begin
            cnt_r <= cnt_r + ROW_W'(1);
            if (cnt_r == total_m1) begin
              state_r <= ST_DRAIN;
            end
          end
        end
        ST_DRAIN: begin
          if (status.adv) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `TCG_ASSERT(a_last_then_drain, (cmd.issue && cmd.last) |=> (state_r == ST_DRAIN))
  `TCG_ASSERT(a_cnt_in_range, (state_r == ST_ROWS) |-> (cnt_r <= total_m1))
  `TCG_ASSERT_MSG(a_drain_holds, ((state_r == ST_DRAIN) && !status.adv) |=> (state_r == ST_DRAIN), "drain left while stalled")

endmodule

/* tb/text_console_glyph_renderer_test.sv */
module text_console_glyph_renderer_test;
  import tcg_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [7:0] CH_TOP = 8'd127;
  localparam int GLYPH_BYTES = (GLYPH_SIZE * GLYPH_SIZE) >> 3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_LIMIT = 10;
  localparam int FINAL_PAUSE = 40;

  typedef struct packed {
    logic [1:0]  act;
    logic [7:0]  code;
    logic [12:0] nx;
    logic [12:0] ny;
    logic [11:0] faddr;
    logic [7:0]  fbyte;
  } console_cmd_t;

  typedef struct packed {
    logic        row_valid;
    logic [12:0] pixel_x;
    logic [12:0] pixel_y;
    logic [27:0] byte_offset;
    logic [15:0] pixel_mask;
    logic [23:0] row_color;
    logic [12:0] cursor_x;
    logic [12:0] cursor_y;
    logic        last;
  } render_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [23:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_action;
  logic [7:0]  in_char_code;
  logic [12:0] in_new_x;
  logic [12:0] in_new_y;
  logic [11:0] in_font_addr;
  logic [7:0]  in_font_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_row_valid;
  logic [12:0] out_pixel_x;
  logic [12:0] out_pixel_y;
  logic [27:0] out_byte_offset;
  logic [15:0] out_pixel_mask;
  logic [23:0] out_row_color;
  logic [12:0] out_cursor_x;
  logic [12:0] out_cursor_y;
  logic        out_last;

  // console state as seen by the predictor
  logic [12:0] cur_col;
  logic [12:0] cur_line;
  logic [7:0]  font_mem [FONT_DEPTH];
  logic [12:0] scr_w;
  logic [12:0] scr_h;
  logic [15:0] pitch_r;
  logic [2:0]  bpp_r;
  logic [23:0] ink_r;
  logic [23:0] paper_r;

  render_row_t pending_rows[$];
  int mismatch_cnt;
  int idle_cycles;
  bit quiet;

  text_console_glyph_renderer dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_char_code(in_char_code),
    .in_new_x(in_new_x),
    .in_new_y(in_new_y),
    .in_font_addr(in_font_addr),
    .in_font_byte(in_font_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_row_valid(out_row_valid),
    .out_pixel_x(out_pixel_x),
    .out_pixel_y(out_pixel_y),
    .out_byte_offset(out_byte_offset),
    .out_pixel_mask(out_pixel_mask),
    .out_row_color(out_row_color),
    .out_cursor_x(out_cursor_x),
    .out_cursor_y(out_cursor_y),
    .out_last(out_last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int idle_len();
    int k;
    if (quiet) return 0;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [12:0] step_col(input logic [12:0] col, input int inc);
    int v;
    v = int'(col) + inc;
    return (v > int'(COORD_MAX)) ? COORD_MAX[12:0] : 13'(v);
  endfunction

  function automatic void predict_render(input console_cmd_t c);
    render_row_t rows[$];
    render_row_t r;
    logic [15:0] clip;
    logic [15:0] glyph_bits;
    logic [23:0] color;
    int glyph;
    int y;
    int p;
    int rr;
    longint unsigned off;
    bit draw;
    bit is_glyph;
    draw = 1'b0;
    is_glyph = 1'b0;
    color = '0;
    glyph = 0;
    case (c.act)
      ACT_CURSOR: begin
        cur_col = c.nx;
        cur_line = c.ny;
      end
      ACT_FONT: begin
        if (int'(c.faddr) < FONT_DEPTH) font_mem[c.faddr] = c.fbyte;
      end
      ACT_CHAR: begin
        if (c.code == CH_NL) begin
          cur_col = '0;
          cur_line = cur_line + 13'(GLYPH_SIZE);
        end else begin
          // line end wraps before the code is handled
          if (cur_col >= scr_w) begin
            cur_col = '0;
            cur_line = cur_line + 13'(GLYPH_SIZE);
          end
          if (c.code == CH_TAB) begin
            cur_col = step_col(cur_col, 4 * GLYPH_SIZE);
          end else if (c.code == CH_BS) begin
            cur_col = (cur_col >= 13'(GLYPH_SIZE)) ? cur_col - 13'(GLYPH_SIZE) : '0;
            draw = 1'b1;
            color = paper_r;
          end else if (c.code >= CH_FIRST && int'(c.code) - int'(CH_FIRST) < GLYPH_COUNT) begin
            draw = 1'b1;
            is_glyph = 1'b1;
            color = ink_r;
            glyph = int'(c.code) - int'(CH_FIRST);
          end
        end
      end
      default: ;
    endcase
    if (draw) begin
      clip = '0;
      for (p = 0; p < GLYPH_SIZE; p++)
        if (int'(cur_col) + p < int'(scr_w)) clip[15-p] = 1'b1;
      for (rr = 0; rr < GLYPH_SIZE; rr++) begin
        y = int'(cur_line) + rr;
        if (y < int'(scr_h)) begin
          r = '0;
          r.row_valid = 1'b1;
          r.pixel_x = cur_col;
          r.pixel_y = 13'(y);
          off = longint'(y) * pitch_r + longint'(cur_col) * bpp_r;
          r.byte_offset = off[27:0];
          glyph_bits = {font_mem[glyph * 32 + 2 * rr], font_mem[glyph * 32 + 2 * rr + 1]};
          r.pixel_mask = (is_glyph ? glyph_bits : 16'hffff) & clip;
          r.row_color = color;
          rows.push_back(r);
        end
      end
    end
    if (is_glyph) cur_col = step_col(cur_col, GLYPH_SIZE);
    if (rows.size() == 0) begin
      r = '0;
      rows.push_back(r);
    end
    foreach (rows[i]) begin
      rows[i].cursor_x = cur_col;
      rows[i].cursor_y = cur_line;
      rows[i].last = (i == rows.size() - 1);
      pending_rows.push_back(rows[i]);
    end
  endfunction

  function automatic console_cmd_t noise_cmd();
    console_cmd_t c;
    c.act = 2'($urandom);
    c.code = 8'($urandom);
    c.nx = 13'($urandom);
    c.ny = 13'($urandom);
    c.faddr = 12'($urandom);
    c.fbyte = 8'($urandom);
    return c;
  endfunction

  function automatic console_cmd_t char_cmd(input logic [7:0] code);
    console_cmd_t c;
    c = noise_cmd();
    c.act = ACT_CHAR;
    c.code = code;
    return c;
  endfunction

  function automatic console_cmd_t cursor_cmd(input logic [12:0] x, input logic [12:0] y);
    console_cmd_t c;
    c = noise_cmd();
    c.act = ACT_CURSOR;
    c.nx = x;
    c.ny = y;
    return c;
  endfunction

  function automatic console_cmd_t font_cmd(input logic [11:0] a, input logic [7:0] b);
    console_cmd_t c;
    c = noise_cmd();
    c.act = ACT_FONT;
    c.faddr = a;
    c.fbyte = b;
    return c;
  endfunction

  function automatic console_cmd_t unused_cmd();
    console_cmd_t c;
    c = noise_cmd();
    c.act = ACT_UNUSED;
    return c;
  endfunction

  // only the first and the last glyph are loaded
  function automatic logic [7:0] pick_char();
    int k;
    k = $urandom_range(0, 99);
    if (k < 70) return ($urandom_range(0, 1) != 0) ? CH_TOP : CH_FIRST;
    if (k < 80) return CH_NL;
    if (k < 88) return CH_TAB;
    if (k < 96) return CH_BS;
    if (k < 98) return 8'($urandom_range(0, 7));
    return 8'($urandom_range(128, 255));
  endfunction

  task automatic send_cmd(input console_cmd_t c);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= c.act;
    in_char_code <= c.code;
    in_new_x <= c.nx;
    in_new_y <= c.ny;
    in_font_addr <= c.faddr;
    in_font_byte <= c.fbyte;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_render(c);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_WIDTH:  scr_w = data[12:0];
      CFG_HEIGHT: scr_h = data[12:0];
      CFG_PITCH:  pitch_r = data[15:0];
      CFG_BPP:    bpp_r = data[2:0];
      CFG_INK:    ink_r = data;
      CFG_PAPER:  paper_r = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic apply_screen(input logic [12:0] w, input logic [12:0] h, input logic [15:0] pitch,
                              input logic [2:0] bpp, input logic [23:0] ink,
                              input logic [23:0] paper);
    settle();
    write_reg(CFG_WIDTH, 24'(w));
    write_reg(CFG_HEIGHT, 24'(h));
    write_reg(CFG_PITCH, 24'(pitch));
    write_reg(CFG_BPP, 24'(bpp));
    write_reg(CFG_INK, ink);
    write_reg(CFG_PAPER, paper);
    cfg_we <= 1'b0;
  endtask

  task automatic test_font_load();
    int a;
    int addr;
    logic [7:0] b;
    quiet = 1'b1;
    for (a = 0; a < 2 * GLYPH_BYTES; a++) begin
      if (a == GLYPH_BYTES) quiet = 1'b0;
      addr = (a < GLYPH_BYTES) ? a : (GLYPH_COUNT - 2) * GLYPH_BYTES + a;
      case ($urandom_range(0, 7))
        0: b = 8'h00;
        1: b = 8'hff;
        default: b = 8'($urandom);
      endcase
      send_cmd(font_cmd(12'(addr), b));
    end
  endtask

  task automatic test_control_codes();
    // reset defaults, out of range font writes must not alias onto real glyphs
    send_cmd(font_cmd(12'(FONT_DEPTH), 8'($urandom)));
    send_cmd(font_cmd(12'hfff, 8'($urandom)));
    send_cmd(char_cmd(CH_FIRST));
    send_cmd(char_cmd(CH_TOP));
    send_cmd(char_cmd(CH_TOP));
    send_cmd(char_cmd(CH_NL));
    send_cmd(char_cmd(CH_TAB));
    send_cmd(char_cmd(CH_BS));
    send_cmd(char_cmd(8'd0));
    send_cmd(char_cmd(8'd31));
    send_cmd(char_cmd(8'd255));
    send_cmd(unused_cmd());
  endtask

  task automatic test_line_wrap();
    apply_screen(13'd40, 13'd768, 16'd320, 3'd2, 24'h123456, 24'h654321);
    send_cmd(cursor_cmd(13'd24, 13'd0));
    send_cmd(char_cmd(CH_FIRST));
    send_cmd(char_cmd(CH_TOP));
    send_cmd(cursor_cmd(13'd32, 13'd0));
    send_cmd(char_cmd(CH_FIRST));
    send_cmd(char_cmd(CH_TAB));
    send_cmd(char_cmd(CH_BS));
    send_cmd(cursor_cmd(13'd0, 13'd8180));
    send_cmd(char_cmd(CH_NL));
  endtask

  task automatic test_clip_suppress();
    apply_screen(13'd1, 13'd1, 16'd1, 3'd1, 24'hffffff, 24'h000000);
    send_cmd(char_cmd(CH_TOP));
    send_cmd(char_cmd(CH_BS));
    send_cmd(char_cmd(CH_FIRST));
    apply_screen(13'd4096, 13'd4096, 16'hffff, 3'd4, 24'h000000, 24'hffffff);
    send_cmd(cursor_cmd(13'd4090, 13'd4088));
    send_cmd(char_cmd(CH_TOP));
    send_cmd(char_cmd(CH_BS));
    send_cmd(cursor_cmd(13'h1fff, 13'h1fff));
    send_cmd(char_cmd(CH_FIRST));
  endtask

  task automatic test_random_phases();
    int ph;
    int cnt;
    int burst;
    int j;
    logic [12:0] w;
    logic [12:0] h;
    logic [15:0] pitch;
    console_cmd_t c;
    for (ph = 0; ph < 2; ph++) begin
      case ($urandom_range(0, 3))
        0: w = 13'd1;
        1: w = 13'd4096;
        default: w = 13'($urandom_range(16, 600));
      endcase
      case ($urandom_range(0, 3))
        0: h = 13'd1;
        1: h = 13'd4096;
        default: h = 13'($urandom_range(8, 400));
      endcase
      case ($urandom_range(0, 3))
        0: pitch = 16'd1;
        1: pitch = 16'hffff;
        default: pitch = 16'($urandom_range(1, 65535));
      endcase
      apply_screen(w, h, pitch, 3'($urandom_range(1, 4)), 24'($urandom), 24'($urandom));
      quiet = (ph == 1);
      cnt = 0;
      while (cnt < 8) begin
        if ($urandom_range(0, 3) != 0) begin
          send_cmd(cursor_cmd(13'($urandom_range(0, int'(w) - 1)),
                              13'($urandom_range(0, int'(h) - 1))));
          burst = $urandom_range(1, 6);
          for (j = 0; j < burst; j++) send_cmd(char_cmd(pick_char()));
          cnt += 1 + burst;
        end else begin
          c = noise_cmd();
          if (c.act == ACT_CHAR) c.code = pick_char();
          send_cmd(c);
          cnt++;
        end
      end
    end
    quiet = 1'b0;
  endtask

  function automatic void show_row(input string tag, input render_row_t r);
    $display("  %s: row_valid=%0d x=%0d y=%0d offset=%h mask=%h color=%h cursor=%0d,%0d last=%0d",
             tag, r.row_valid, r.pixel_x, r.pixel_y, r.byte_offset, r.pixel_mask, r.row_color,
             r.cursor_x, r.cursor_y, r.last);
  endfunction

  always @(posedge clk) begin : check_rows
    render_row_t got;
    render_row_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_row_valid, out_pixel_x, out_pixel_y, out_byte_offset, out_pixel_mask,
             out_row_color, out_cursor_x, out_cursor_y, out_last};
      if (pending_rows.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_LIMIT) begin
          $display("unexpected result transfer");
          show_row("actual", got);
        end
      end else begin
        want = pending_rows.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_LIMIT) begin
            $display("result mismatch");
            show_row("expected", want);
            show_row("actual", got);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("text_console_glyph_renderer regression: fail");
        $finish;
      end
    end
  end

  initial begin : stall_gen
    int n;
    out_stall = 1'b0;
    forever begin
      n = $urandom_range(1, 30);
      repeat (n) @(posedge clk);
      n = idle_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_action = ACT_CHAR;
    in_char_code = '0;
    in_new_x = '0;
    in_new_y = '0;
    in_font_addr = '0;
    in_font_byte = '0;
    quiet = 1'b0;
    cur_col = '0;
    cur_line = '0;
    scr_w = WIDTH_RST;
    scr_h = HEIGHT_RST;
    pitch_r = PITCH_RST;
    bpp_r = BPP_RST;
    ink_r = INK_RST;
    paper_r = PAPER_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_font_load();
    test_control_codes();
    test_line_wrap();
    test_clip_suppress();
    test_random_phases();
    settle();
    repeat (FINAL_PAUSE) @(posedge clk);
    if (mismatch_cnt == 0 && pending_rows.size() == 0) begin
      $display("text_console_glyph_renderer regression: pass");
    end else begin
      $display("text_console_glyph_renderer regression: fail");
    end
    $finish;
  end

endmodule
